### rtl/i2c_mts_pkg.sv
// Shared types, codes and constants of the I2C master transaction sequencer.
package i2c_mts_pkg;

	localparam int LENGTH_BITS_DEF = 16;
	localparam int COUNT_W         = 16;
	localparam int TIMEOUT_W       = 17;
	localparam int FLAGS_W         = 9;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 17'd100000;
	localparam logic READ_DIR_BIT  = 1'b1;
	localparam logic WRITE_DIR_BIT = 1'b0;

	localparam int FLAG_SB   = 0;
	localparam int FLAG_ADDR = 1;
	localparam int FLAG_TXE  = 2;
	localparam int FLAG_RXNE = 3;
	localparam int FLAG_BTF  = 4;
	localparam int FLAG_NACK = 5;
	localparam int FLAG_BERR = 6;
	localparam int FLAG_ARLO = 7;
	localparam int FLAG_BUSY = 8;

	typedef enum logic {
		CMD_BEGIN  = 1'b0,
		CMD_SAMPLE = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		MODE_WRITE      = 2'd0,
		MODE_READ       = 2'd1,
		MODE_WRITE_READ = 2'd2,
		MODE_BAD        = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ACT_NONE         = 3'd0,
		ACT_START        = 3'd1,
		ACT_STOP         = 3'd2,
		ACT_CLR_ACK      = 3'd3,
		ACT_CLR_ACK_STOP = 3'd4,
		ACT_SET_ACK      = 3'd5
	} action_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NACK    = 3'd1,
		ST_BERR    = 3'd2,
		ST_ARLO    = 3'd3,
		ST_TIMEOUT = 3'd4
	} status_t;

	typedef struct packed {
		command_t             command;
		mode_t                mode;
		logic [6:0]           slave_address;
		logic [COUNT_W-1:0]   write_count;
		logic [COUNT_W-1:0]   read_count;
		logic [FLAGS_W-1:0]   status_flags;
		logic [7:0]           rx_byte;
		logic [7:0]           tx_byte;
	} item_t;

	typedef struct packed {
		action_t    bus_action;
		logic       dr_write_valid;
		logic [7:0] dr_write_value;
		logic       tx_taken;
		logic       addr_clear;
		logic       error_clear;
		logic       rx_valid;
		logic [7:0] rx_value;
		logic       done_res;
		status_t    status;
	} result_t;

endpackage

### rtl/i2c_master_transaction_sequencer_unit.sv
// Top level of the I2C master transaction sequencer.
//
//   channel  direction  handshake          contents
//   in       to block   in_valid/in_stall  command, mode, address, counts, flags, bytes
//   out      from block out_valid/out_stall bus action, byte writes, rx byte, completion
//   cfg      to block   cfg_write_en        timeout_limit
//
// One word per clock unless stalled: a word enters the input register, is decided
// in one pass against the transaction state, then moves to the result register or skid.
// out_valid marks a word in the result register; it leaves once out_stall is low.
// Every input word yields exactly one output word (all zero when ignored).
// Reset clears the state to idle and sets timeout_limit to 100000.
// A stalled output fills the skid entry, then in_stall rises.
module i2c_master_transaction_sequencer_unit
	import i2c_mts_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [1:0]           mode,
	input  logic [6:0]           slave_address,
	input  logic [COUNT_W-1:0]   write_count,
	input  logic [COUNT_W-1:0]   read_count,
	input  logic [FLAGS_W-1:0]   status_flags,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           tx_byte,
	input  logic                 cfg_write_en,
	input  logic [TIMEOUT_W-1:0] cfg_write_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           bus_action,
	output logic                 dr_write_valid,
	output logic [7:0]           dr_write_value,
	output logic                 tx_taken,
	output logic                 addr_clear,
	output logic                 error_clear,
	output logic                 rx_valid,
	output logic [7:0]           rx_value,
	output logic                 done_res,
	output logic [2:0]           status
);

	item_t   in_item;
	result_t res;
	result_t out_data;
	logic    res_push;
	logic    res_ready;

	assign in_item.command       = command_t'(command);
	assign in_item.mode          = mode_t'(mode);
	assign in_item.slave_address = slave_address;
	assign in_item.write_count   = write_count;
	assign in_item.read_count    = read_count;
	assign in_item.status_flags  = status_flags;
	assign in_item.rx_byte       = rx_byte;
	assign in_item.tx_byte       = tx_byte;

	i2c_mts_seq #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_item       (in_item),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.res_ready     (res_ready),
		.res_push      (res_push),
		.res           (res)
	);

	i2c_mts_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.push_data(res),
		.ready    (res_ready),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	assign bus_action     = out_data.bus_action;
	assign dr_write_valid = out_data.dr_write_valid;
	assign dr_write_value = out_data.dr_write_value;
	assign tx_taken       = out_data.tx_taken;
	assign addr_clear     = out_data.addr_clear;
	assign error_clear    = out_data.error_clear;
	assign rx_valid       = out_data.rx_valid;
	assign rx_value       = out_data.rx_value;
	assign done_res       = out_data.done_res;
	assign status         = out_data.status;

endmodule

### rtl/i2c_mts_seq.sv
// Input register, transaction state and next-step decision of the sequencer.
module i2c_mts_seq
	import i2c_mts_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  item_t                in_item,
	input  logic                 cfg_write_en,
	input  logic [TIMEOUT_W-1:0] cfg_write_data,
	input  logic                 res_ready,
	output logic                 res_push,
	output result_t              res
);

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_SB_W   = 4'd1,
		PH_ADDR_W = 4'd2,
		PH_TXE    = 4'd3,
		PH_BTF    = 4'd4,
		PH_SB_R   = 4'd5,
		PH_ADDR_R = 4'd6,
		PH_RXNE   = 4'd7,
		PH_STOP   = 4'd8
	} phase_t;

	localparam int LW = LENGTH_BITS;

	logic                 valid_s1;
	item_t                item_s1;

	phase_t               phase_q, phase_n;
	logic [TIMEOUT_W-1:0] wait_q, wait_n;
	logic [TIMEOUT_W-1:0] limit_q;
	logic [LW-1:0]        index_q, index_n;
	logic [LW-1:0]        wtotal_q, wtotal_n;
	logic [LW-1:0]        rtotal_q, rtotal_n;
	mode_t                mode_q, mode_n;
	logic [6:0]           addr_q, addr_n;
	status_t              pend_q, pend_n;

	logic [TIMEOUT_W-1:0] wait_inc;
	logic                 expired;
	logic [LW-1:0]        index_inc;
	logic [LW-1:0]        wcount_l;
	logic [LW-1:0]        rcount_l;
	status_t              err_code;
	logic [FLAGS_W-1:0]   flags;
	logic                 accept;

	assign accept   = in_valid && !in_stall;
	assign in_stall = valid_s1 && !res_ready;
	assign res_push = valid_s1 && res_ready;

	assign flags     = item_s1.status_flags;
	assign wait_inc  = wait_q + TIMEOUT_W'(1);
	assign expired   = wait_inc >= limit_q;
	assign index_inc = index_q + LW'(1);
	assign wcount_l  = item_s1.write_count[LW-1:0];
	assign rcount_l  = item_s1.read_count[LW-1:0];

	always_comb begin
		priority if (flags[FLAG_NACK]) begin
			err_code = ST_NACK;
		end else if (flags[FLAG_BERR]) begin
			err_code = ST_BERR;
		end else if (flags[FLAG_ARLO]) begin
			err_code = ST_ARLO;
		end else begin
			err_code = ST_OK;
		end
	end

	always_comb begin
		phase_n  = phase_q;
		wait_n   = wait_q;
		index_n  = index_q;
		wtotal_n = wtotal_q;
		rtotal_n = rtotal_q;
		mode_n   = mode_q;
		addr_n   = addr_q;
		pend_n   = pend_q;
		res      = '0;

		if (item_s1.command == CMD_BEGIN) begin
			if (phase_q == PH_IDLE && item_s1.mode != MODE_BAD) begin
				mode_n   = item_s1.mode;
				addr_n   = item_s1.slave_address;
				wtotal_n = wcount_l;
				rtotal_n = rcount_l;
				index_n  = '0;
				pend_n   = ST_OK;
				wait_n   = '0;
				if (item_s1.mode == MODE_READ) begin
					if (rcount_l == '0) begin
						res.done_res = 1'b1;
						res.status   = ST_OK;
						phase_n      = PH_IDLE;
					end else begin
						res.bus_action = ACT_START;
						phase_n        = PH_SB_R;
					end
				end else begin
					res.bus_action = ACT_START;
					phase_n        = PH_SB_W;
				end
			end
		end else begin
			unique case (phase_q)
				PH_SB_W, PH_SB_R: begin
					if (flags[FLAG_SB]) begin
						res.error_clear    = 1'b1;
						res.dr_write_valid = 1'b1;
						wait_n             = '0;
						if (phase_q == PH_SB_R) begin
							res.bus_action     = ACT_SET_ACK;
							res.dr_write_value = {addr_q, READ_DIR_BIT};
							phase_n            = PH_ADDR_R;
						end else begin
							res.dr_write_value = {addr_q, WRITE_DIR_BIT};
							phase_n            = PH_ADDR_W;
						end
					end else if (expired) begin
						res.done_res = 1'b1;
						res.status   = ST_TIMEOUT;
						phase_n      = PH_IDLE;
						wait_n       = '0;
					end else begin
						wait_n = wait_inc;
					end
				end
				PH_ADDR_W, PH_ADDR_R: begin
					if (flags[FLAG_ADDR]) begin
						res.addr_clear = 1'b1;
						index_n        = '0;
						wait_n         = '0;
						if (phase_q == PH_ADDR_W) begin
							phase_n = (wtotal_q == '0) ? PH_BTF : PH_TXE;
						end else begin
							if ({1'b0, rtotal_q} <= (LW+1)'(2)) begin
								res.bus_action = ACT_CLR_ACK_STOP;
							end
							phase_n = PH_RXNE;
						end
					end else if (err_code != ST_OK) begin
						res.bus_action  = ACT_STOP;
						res.error_clear = 1'b1;
						pend_n          = err_code;
						phase_n         = PH_STOP;
						wait_n          = '0;
					end else if (expired) begin
						res.bus_action = ACT_STOP;
						pend_n         = ST_TIMEOUT;
						phase_n        = PH_STOP;
						wait_n         = '0;
					end else begin
						wait_n = wait_inc;
					end
				end
				PH_TXE: begin
					if (flags[FLAG_TXE]) begin
						res.dr_write_valid = 1'b1;
						res.dr_write_value = item_s1.tx_byte;
						res.tx_taken       = 1'b1;
						index_n            = index_inc;
						wait_n             = '0;
						phase_n            = (index_inc >= wtotal_q) ? PH_BTF : PH_TXE;
					end else if (err_code != ST_OK) begin
						res.bus_action  = ACT_STOP;
						res.error_clear = 1'b1;
						pend_n          = err_code;
						phase_n         = PH_STOP;
						wait_n          = '0;
					end else if (expired) begin
						res.bus_action = ACT_STOP;
						pend_n         = ST_TIMEOUT;
						phase_n        = PH_STOP;
						wait_n         = '0;
					end else begin
						wait_n = wait_inc;
					end
				end
				PH_BTF: begin
					if (flags[FLAG_BTF]) begin
						wait_n = '0;
						if (mode_q == MODE_WRITE_READ && rtotal_q != '0) begin
							res.bus_action = ACT_START;
							phase_n        = PH_SB_R;
						end else begin
							res.bus_action = ACT_STOP;
							pend_n         = ST_OK;
							phase_n        = PH_STOP;
						end
					end else if (expired) begin
						res.bus_action = ACT_STOP;
						pend_n         = ST_TIMEOUT;
						phase_n        = PH_STOP;
						wait_n         = '0;
					end else begin
						wait_n = wait_inc;
					end
				end
				PH_RXNE: begin
					if (flags[FLAG_RXNE]) begin
						res.rx_valid = 1'b1;
						res.rx_value = item_s1.rx_byte;
						index_n      = index_inc;
						wait_n       = '0;
						if (index_inc >= rtotal_q) begin
							res.done_res = 1'b1;
							res.status   = ST_OK;
							phase_n      = PH_IDLE;
						end else if ({1'b0, index_inc} + (LW+1)'(2) == {1'b0, rtotal_q}) begin
							res.bus_action = ACT_CLR_ACK_STOP;
						end
					end else if (err_code != ST_OK) begin
						res.bus_action  = ACT_STOP;
						res.error_clear = 1'b1;
						pend_n          = err_code;
						phase_n         = PH_STOP;
						wait_n          = '0;
					end else if (expired) begin
						res.done_res = 1'b1;
						res.status   = ST_TIMEOUT;
						phase_n      = PH_IDLE;
						wait_n       = '0;
					end else begin
						wait_n = wait_inc;
					end
				end
				PH_STOP: begin
					if (!flags[FLAG_BUSY]) begin
						res.done_res = 1'b1;
						res.status   = pend_q;
						phase_n      = PH_IDLE;
						wait_n       = '0;
					end else if (expired) begin
						res.done_res = 1'b1;
						res.status   = (pend_q != ST_OK) ? pend_q : ST_TIMEOUT;
						phase_n      = PH_IDLE;
						wait_n       = '0;
					end else begin
						wait_n = wait_inc;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_IDLE;
			wait_q   <= '0;
			index_q  <= '0;
			wtotal_q <= '0;
			rtotal_q <= '0;
			mode_q   <= MODE_WRITE;
			addr_q   <= '0;
			pend_q   <= ST_OK;
			limit_q  <= TIMEOUT_RESET;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (res_push) begin
				valid_s1 <= 1'b0;
			end
			if (res_push) begin
				phase_q  <= phase_n;
				wait_q   <= wait_n;
				index_q  <= index_n;
				wtotal_q <= wtotal_n;
				rtotal_q <= rtotal_n;
				mode_q   <= mode_n;
				addr_q   <= addr_n;
				pend_q   <= pend_n;
			end
			if (cfg_write_en) begin
				limit_q <= cfg_write_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.done_res |=> phase_q == PH_IDLE)
		else $error("phase not idle after a completion word");

	a_wait_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		wait_q == '0 || wait_q < limit_q)
		else $error("wait counter reached the timeout limit");

	a_one_byte_source: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !(res.rx_valid && res.dr_write_valid))
		else $error("received and transmitted byte in one word");

endmodule

### rtl/i2c_mts_obuf.sv
// Result register with a skid entry between the sequencer and the output channel.
module i2c_mts_obuf
	import i2c_mts_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    ready,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    drain;

	assign ready     = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign drain     = !main_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry held without a result in front");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ready)
		else $error("word pushed into a full buffer");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !out_stall |=> !skid_valid_q)
		else $error("skid entry not moved forward");

endmodule
